/* rtl/fsls_pkg.sv */
// Package for the framed score list sorter.
// Holds item structs, command and status codes, and controller/datapath links.
// No dependencies.
package fsls_pkg;

    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_CLOSE = 3'd1;
    localparam logic [2:0] CMD_ALLOC = 3'd2;
    localparam logic [2:0] CMD_SORT  = 3'd3;
    localparam logic [2:0] CMD_FIRST = 3'd4;
    localparam logic [2:0] CMD_NEXT  = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_STORE_FULL = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [1:0] ST_NO_FRAME   = 2'd3;

    localparam logic signed [31:0] TOP_SCORE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] score;
        logic [10:0]        slot;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        slot_out;
        logic signed [31:0] score_out;
        logic               found;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_ZERO  = 2'd1,
        RES_ALLOC = 2'd2,
        RES_RAM   = 2'd3
    } t_res_op;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_HEAD = 2'd1,
        RD_LINK = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic       cap;
        logic       open;
        logic       close;
        logic       cl_load;
        logic       alloc;
        logic       score_rd;
        t_rd_sel    rd_sel;
        logic       sort_init;
        logic       scan;
        logic       pass2;
        logic       pass_start;
        logic       pass_next;
        t_res_op    res_op;
        logic [1:0] res_status;
        logic       emit;
    } t_ctrl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       depth_zero;
        logic       depth_full;
        logic       depth_ge2;
        logic       fp_full;
        logic       slot_ok;
        logic       head_valid;
        logic       scan_busy;
        logic       any;
        logic       link_valid;
        logic       out_free;
    } t_stat;

endpackage

/* rtl/fsls_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fsls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/fsls_dp.sv */
// Datapath: slot score/link memories, frame stack memory, sort scan, output register.
// Depends on fsls_pkg and fsls_ram.
module fsls_dp import fsls_pkg::*; #(
    parameter int STORE_SLOTS = 2048,
    parameter int MAX_FRAMES  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);
    localparam int SW  = $clog2(STORE_SLOTS);
    localparam int CW  = $clog2(STORE_SLOTS + 1);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int DW  = $clog2(MAX_FRAMES + 1);
    localparam int FRW = CW + SW + 1;

    t_in_item           r_in;
    t_out_item          r_res, r_out;
    logic               r_ovalid;
    logic [CW-1:0]      r_fp, r_base, r_idx;
    logic [DW-1:0]      r_depth;
    logic [SW-1:0]      r_head, r_ridx, r_oslot;
    logic               r_hv, r_any, r_rv;
    logic signed [31:0] r_low, r_best;

    logic [31:0]        score_rdata;
    logic [SW:0]        link_rdata;
    logic [FRW-1:0]     frame_rdata;
    logic [SW-1:0]      score_raddr, link_waddr;
    logic               link_we, issue, hit;

    assign issue = r_idx < r_fp;
    assign hit   = i_ctrl.scan && i_ctrl.pass2 && r_rv && ($signed(score_rdata) == r_best);

    always_comb begin
        unique case (i_ctrl.rd_sel)
            RD_HEAD: score_raddr = r_head;
            RD_LINK: score_raddr = link_rdata[SW-1:0];
            default: score_raddr = r_idx[SW-1:0];
        endcase
    end

    assign link_we    = i_ctrl.alloc || hit;
    assign link_waddr = i_ctrl.alloc ? r_fp[SW-1:0] : r_ridx;

    fsls_ram #(.WIDTH(32), .DEPTH(STORE_SLOTS)) u_score_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.alloc),
        .i_waddr(r_fp[SW-1:0]),
        .i_wdata(r_in.score),
        .i_raddr(score_raddr),
        .o_rdata(score_rdata)
    );

    fsls_ram #(.WIDTH(SW + 1), .DEPTH(STORE_SLOTS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata({r_hv, r_head}),
        .i_raddr(SW'(r_in.slot)),
        .o_rdata(link_rdata)
    );

    fsls_ram #(.WIDTH(FRW), .DEPTH(MAX_FRAMES)) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.open && (r_depth != '0)),
        .i_waddr(FW'(r_depth - DW'(1))),
        .i_wdata({r_base, r_head, r_hv}),
        .i_raddr(FW'(r_depth - DW'(2))),
        .o_rdata(frame_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp     <= '0;
            r_depth  <= '0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (i_ctrl.cap) begin
                r_in <= i_in_data;
            end
            if (i_ctrl.open) begin
                r_base  <= (r_depth == '0) ? '0 : r_fp;
                r_fp    <= (r_depth == '0) ? '0 : r_fp;
                r_head  <= '0;
                r_hv    <= 1'b0;
                r_depth <= r_depth + DW'(1);
            end
            if (i_ctrl.close) begin
                r_fp    <= r_base;
                r_depth <= r_depth - DW'(1);
            end
            if (i_ctrl.cl_load) begin
                {r_base, r_head, r_hv} <= frame_rdata;
            end
            if (i_ctrl.alloc) begin
                r_head <= r_fp[SW-1:0];
                r_hv   <= 1'b1;
                r_fp   <= r_fp + CW'(1);
            end
            if (i_ctrl.score_rd) begin
                r_oslot <= score_raddr;
            end
            if (i_ctrl.sort_init) begin
                r_low  <= '0;
                r_best <= TOP_SCORE;
                r_any  <= 1'b0;
                r_head <= '0;
                r_hv   <= 1'b0;
            end
            if (i_ctrl.pass_next) begin
                r_low  <= r_best;
                r_best <= TOP_SCORE;
                r_any  <= 1'b0;
            end
            if (i_ctrl.sort_init || i_ctrl.pass_start) begin
                r_idx <= r_base;
                r_rv  <= 1'b0;
            end else if (i_ctrl.scan) begin
                r_rv   <= issue;
                r_ridx <= r_idx[SW-1:0];
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rv && !i_ctrl.pass2 && (r_low < $signed(score_rdata))
                        && ($signed(score_rdata) < r_best)) begin
                    r_best <= $signed(score_rdata);
                    r_any  <= 1'b1;
                end
                if (hit) begin
                    r_head <= r_ridx;
                    r_hv   <= 1'b1;
                end
            end
            case (i_ctrl.res_op)
                RES_ZERO:  r_res <= '{slot_out: '0, score_out: '0, found: 1'b0,
                                      status: i_ctrl.res_status};
                RES_ALLOC: r_res <= '{slot_out: 11'(r_fp), score_out: r_in.score,
                                      found: 1'b1, status: ST_OK};
                RES_RAM:   r_res <= '{slot_out: 11'(r_oslot), score_out: score_rdata,
                                      found: 1'b1, status: ST_OK};
                default:   ;
            endcase
            if (i_ctrl.emit) begin
                r_out    <= r_res;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.cmd        = r_in.cmd;
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.depth_full = (r_depth >= DW'(MAX_FRAMES));
    assign o_stat.depth_ge2  = (r_depth >= DW'(2));
    assign o_stat.fp_full    = (r_fp >= CW'(STORE_SLOTS));
    assign o_stat.slot_ok    = (32'(r_in.slot) < 32'(STORE_SLOTS));
    assign o_stat.head_valid = r_hv;
    assign o_stat.scan_busy  = issue || r_rv;
    assign o_stat.any        = r_any;
    assign o_stat.link_valid = link_rdata[SW];
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

/* rtl/fsls_ctrl.sv */
// Controller state machine: decodes each item and sequences the datapath.
// Depends on fsls_pkg.
module fsls_ctrl import fsls_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DEC  = 8'b0000_0010,
        S_NX   = 8'b0000_0100,
        S_CL   = 8'b0000_1000,
        S_RDS  = 8'b0001_0000,
        S_P1   = 8'b0010_0000,
        S_P2   = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.cap = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_state         = S_EMIT;
                o_ctrl.res_op   = RES_ZERO;
                o_ctrl.res_status = ST_OK;
                if (i_stat.cmd == CMD_OPEN) begin
                    if (i_stat.depth_full) o_ctrl.res_status = ST_STACK_FULL;
                    else o_ctrl.open = 1'b1;
                end else if (i_stat.cmd == CMD_NEXT) begin
                    if (i_stat.slot_ok) begin
                        o_ctrl.res_op = RES_NONE;
                        n_state       = S_NX;
                    end
                end else if (i_stat.cmd > CMD_NEXT) begin
                    o_ctrl.res_status = ST_OK;
                end else if (i_stat.depth_zero) begin
                    o_ctrl.res_status = ST_NO_FRAME;
                end else if (i_stat.cmd == CMD_CLOSE) begin
                    o_ctrl.close = 1'b1;
                    if (i_stat.depth_ge2) n_state = S_CL;
                end else if (i_stat.cmd == CMD_ALLOC) begin
                    if (i_stat.fp_full) begin
                        o_ctrl.res_status = ST_STORE_FULL;
                    end else begin
                        o_ctrl.alloc  = 1'b1;
                        o_ctrl.res_op = RES_ALLOC;
                    end
                end else if (i_stat.cmd == CMD_SORT) begin
                    o_ctrl.res_op    = RES_NONE;
                    o_ctrl.sort_init = 1'b1;
                    n_state          = S_P1;
                end else if (i_stat.head_valid) begin
                    o_ctrl.res_op   = RES_NONE;
                    o_ctrl.score_rd = 1'b1;
                    o_ctrl.rd_sel   = RD_HEAD;
                    n_state         = S_RDS;
                end
            end
            S_NX: begin
                if (i_stat.link_valid) begin
                    o_ctrl.score_rd = 1'b1;
                    o_ctrl.rd_sel   = RD_LINK;
                    n_state         = S_RDS;
                end else begin
                    o_ctrl.res_op = RES_ZERO;
                    n_state       = S_EMIT;
                end
            end
            S_CL: begin
                o_ctrl.cl_load = 1'b1;
                o_ctrl.res_op  = RES_ZERO;
                n_state        = S_EMIT;
            end
            S_RDS: begin
                o_ctrl.res_op = RES_RAM;
                n_state       = S_EMIT;
            end
            S_P1: begin
                o_ctrl.scan = 1'b1;
                if (!i_stat.scan_busy) begin
                    if (i_stat.any) begin
                        o_ctrl.pass_start = 1'b1;
                        n_state           = S_P2;
                    end else if (i_stat.head_valid) begin
                        o_ctrl.score_rd = 1'b1;
                        o_ctrl.rd_sel   = RD_HEAD;
                        n_state         = S_RDS;
                    end else begin
                        o_ctrl.res_op = RES_ZERO;
                        n_state       = S_EMIT;
                    end
                end
            end
            S_P2: begin
                o_ctrl.scan  = 1'b1;
                o_ctrl.pass2 = 1'b1;
                if (!i_stat.scan_busy) begin
                    o_ctrl.pass_next  = 1'b1;
                    o_ctrl.pass_start = 1'b1;
                    n_state           = S_P1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

/* rtl/framed_score_list_sorter.sv */
// Top level of the framed score list sorter.
// Depends on fsls_pkg, fsls_ctrl, fsls_dp (and fsls_ram through fsls_dp).
//
// Input channel i_in_valid/o_in_ready/i_in_data carries one command item
// (open, close, allocate, sort, first, next); every item yields exactly one
// result item on o_out_valid/i_out_ready/o_out_data.
// One item at a time: o_in_ready is high only while the controller is idle.
// Open, allocate, unknown commands and close of the bottom frame go from decode
// straight to emit; close of an upper frame adds a frame reload state, first a
// score read of the head, next a link read then a score read (registered reads).
// Sort scans the frame's slots through the score memory read port, one slot
// per cycle, and runs 2*D+1 scans for D distinct kept scores.
// Results sit in an output register; a new item is taken while one waits,
// and a stalled receiver holds the next result in the emit state.
// Synchronous reset empties the frame stack and the free pointer; memories
// are not cleared and need no clearing pass.
module framed_score_list_sorter import fsls_pkg::*; #(
    parameter int STORE_SLOTS = 2048,
    parameter int MAX_FRAMES  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    t_ctrl ctrl;
    t_stat stat;

    fsls_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_ctrl    (ctrl)
    );

    fsls_dp #(.STORE_SLOTS(STORE_SLOTS), .MAX_FRAMES(MAX_FRAMES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_in_data  (i_in_data),
        .i_out_ready(i_out_ready),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );
endmodule
